// File: sv/zrd_pkg.sv
// ----------------------------------------------------------------------------
// Zigzag reversal detector package
// Shared widths, constants, result codes and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package zrd_pkg;

  localparam int PRICE_W_DEFAULT = 32;
  localparam int PORT_PRICE_W    = 32;
  localparam int THRESH_W        = 16;
  localparam int PCT_SCALE       = 100;
  localparam int PCT_SCALE_SQ    = PCT_SCALE * PCT_SCALE;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd500;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_TROUGH = 2'd1,
    MARK_PEAK   = 2'd2
  } mark_kind_t;

  typedef struct packed {
    logic [PORT_PRICE_W-1:0] price;
    logic                    start_of_series;
  } in_word_t;

  typedef struct packed {
    mark_kind_t              mark_kind;
    logic [PORT_PRICE_W-1:0] mark_value;
  } out_word_t;

endpackage

`default_nettype wire

// File: sv/zrd_if.sv
// ----------------------------------------------------------------------------
// Zigzag reversal detector channels
// Valid/ready channels for the sample words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface zrd_in_if;
  import zrd_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface zrd_out_if;
  import zrd_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/zigzag_reversal_detector_core.sv
// ----------------------------------------------------------------------------
// Zigzag reversal detector core
// Tracks a running maximum and minimum of a price stream and reports a
// confirmed trough or peak when the reversal exceeds a percentage threshold.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Word
//   in_ch    sink       valid/ready         price, start_of_series
//   out_ch   source     valid/ready         mark_kind, mark_value
//   cfg      sink       cfg_we, no ready    threshold_centipercent
//
// One word is accepted per cycle while out_ch is not stalled, and each gives one
// result word on out_ch, after an input register, then the compare and update
// logic with its two multipliers, then the result register. Reset is
// synchronous; it loads the threshold with 500 and zeroes the extremes and the
// direction flags. A stall on out_ch holds the result register and a full input
// register, and drops in_ch.ready only while the input register is full.
`default_nettype none

module zigzag_reversal_detector_core #(
  parameter int PRICE_WIDTH = zrd_pkg::PRICE_W_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  zrd_in_if.sink                             in_ch,
  zrd_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [zrd_pkg::THRESH_W-1:0]  cfg_wdata
);
  import zrd_pkg::*;

  localparam int ProdW = PRICE_WIDTH + THRESH_W;

  logic [THRESH_W-1:0]    thresh_r;
  logic                   s1_valid_r;
  logic [PRICE_WIDTH-1:0] s1_price_r;
  logic                   s1_start_r;

  logic [PRICE_WIDTH-1:0] max_r, max_nxt;
  logic [PRICE_WIDTH-1:0] min_r, min_nxt;
  logic                   seek_low_r, seek_low_nxt;
  logic                   seek_high_r, seek_high_nxt;

  logic                   out_valid_r;
  out_word_t              out_word_r, out_word_nxt;

  logic                   advance;
  logic [PRICE_WIDTH-1:0] max_eff, min_eff;
  logic                   seek_low_eff, seek_high_eff;
  logic                   rise, fall;
  logic [PRICE_WIDTH-1:0] diff, base;
  logic [ProdW-1:0]       lhs_prod, rhs_prod;
  logic                   exceeds;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  always_comb begin
    max_eff       = s1_start_r ? s1_price_r : max_r;
    min_eff       = s1_start_r ? s1_price_r : min_r;
    seek_low_eff  = s1_start_r ? 1'b0 : seek_low_r;
    seek_high_eff = s1_start_r ? 1'b0 : seek_high_r;

    // The minimum never exceeds the maximum, so a rise excludes a fall.
    rise = s1_price_r > max_eff;
    fall = !rise && (s1_price_r < min_eff);

    diff = rise ? (s1_price_r - min_eff) : (max_eff - s1_price_r);
    base = rise ? min_eff : max_eff;

    lhs_prod = ProdW'(diff) * ProdW'(PCT_SCALE_SQ);
    rhs_prod = ProdW'(thresh_r) * ProdW'(base);
    exceeds  = lhs_prod > rhs_prod;

    max_nxt       = max_eff;
    min_nxt       = min_eff;
    seek_low_nxt  = seek_low_eff;
    seek_high_nxt = seek_high_eff;
    out_word_nxt.mark_kind  = MARK_NONE;
    out_word_nxt.mark_value = '0;

    priority if (rise) begin
      max_nxt = s1_price_r;
      if (seek_low_eff) begin
        min_nxt = s1_price_r;
      end else if (exceeds) begin
        out_word_nxt.mark_kind  = MARK_TROUGH;
        out_word_nxt.mark_value = PORT_PRICE_W'(min_eff);
        min_nxt       = s1_price_r;
        seek_low_nxt  = 1'b1;
        seek_high_nxt = 1'b0;
      end
    end else if (fall) begin
      min_nxt = s1_price_r;
      if (seek_high_eff) begin
        max_nxt = s1_price_r;
      end else if (exceeds) begin
        out_word_nxt.mark_kind  = MARK_PEAK;
        out_word_nxt.mark_value = PORT_PRICE_W'(max_eff);
        max_nxt       = s1_price_r;
        seek_high_nxt = 1'b1;
        seek_low_nxt  = 1'b0;
      end
    end else begin
      max_nxt = max_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= '0;
      min_r       <= '0;
      seek_low_r  <= 1'b0;
      seek_high_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          max_r       <= max_nxt;
          min_r       <= min_nxt;
          seek_low_r  <= seek_low_nxt;
          seek_high_r <= seek_high_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_price_r <= PRICE_WIDTH'(in_ch.data.price);
      s1_start_r <= in_ch.data.start_of_series;
    end
    if (advance && s1_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= max_r)
    else $error("Running minimum rose above running maximum.");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    !(seek_low_r && seek_high_r))
    else $error("Both direction flags are set.");

  a_no_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.mark_kind == MARK_NONE) |-> out_word_r.mark_value == '0)
    else $error("Result word without a mark carries a nonzero value.");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_price_r))
    else $error("Input register changed during an output stall.");

endmodule

`default_nettype wire

// File: test/zrd_mark_check.sv
// ----------------------------------------------------------------------------
// Zigzag reversal detector mark checker
// Watches the sample, result and threshold ports of the core. It keeps its
// own copy of the extremes and the swing flags, works out the mark that each
// accepted sample must give, and compares every result word with the oldest
// mark still awaited.
// ----------------------------------------------------------------------------
`default_nettype none

module zrd_mark_check (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  zrd_in_if                          in_mon,
  zrd_out_if                         out_mon,
  input  wire logic                  cfg_we,
  input  wire logic [zrd_pkg::THRESH_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         samples_seen,
  output int                         troughs_seen,
  output int                         peaks_seen
);
  import zrd_pkg::*;

  logic [THRESH_W-1:0]     threshold;
  logic [PORT_PRICE_W-1:0] high_water;
  logic [PORT_PRICE_W-1:0] low_water;
  logic                    after_trough;
  logic                    after_peak;
  out_word_t               awaited_marks[$];

  initial begin
    mismatches   = 0;
    samples_seen = 0;
    troughs_seen = 0;
    peaks_seen   = 0;
    outstanding  = 0;
  end

  function automatic bit beyond_threshold(logic [PORT_PRICE_W-1:0] diff,
                                          logic [PORT_PRICE_W-1:0] base);
    logic [63:0] move_side;
    logic [63:0] limit_side;
    move_side  = 64'(diff) * 64'(PCT_SCALE_SQ);
    limit_side = 64'(threshold) * 64'(base);
    return move_side > limit_side;
  endfunction

  function automatic out_word_t next_mark(in_word_t w);
    out_word_t mark;
    mark.mark_kind  = MARK_NONE;
    mark.mark_value = '0;
    if (w.start_of_series) begin
      high_water   = w.price;
      low_water    = w.price;
      after_trough = 1'b0;
      after_peak   = 1'b0;
    end
    if (w.price > high_water) begin
      high_water = w.price;
      if (after_trough) begin
        low_water = high_water;
      end else if (beyond_threshold(high_water - low_water, low_water)) begin
        mark.mark_kind  = MARK_TROUGH;
        mark.mark_value = low_water;
        low_water       = high_water;
        after_trough    = 1'b1;
        after_peak      = 1'b0;
      end
    end
    if (w.price < low_water) begin
      low_water = w.price;
      if (after_peak) begin
        high_water = low_water;
      end else if (beyond_threshold(high_water - low_water, high_water)) begin
        mark.mark_kind  = MARK_PEAK;
        mark.mark_value = high_water;
        high_water      = low_water;
        after_peak      = 1'b1;
        after_trough    = 1'b0;
      end
    end
    return mark;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    out_word_t mark;
    if (!rst_n) begin
      threshold    = THRESH_RESET;
      high_water   = '0;
      low_water    = '0;
      after_trough = 1'b0;
      after_peak   = 1'b0;
      awaited_marks.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_marks.size() == 0) begin
          report_mismatch("unrequested result word", out_mon.data.mark_value, '0);
        end else begin
          want = awaited_marks.pop_front();
          if (out_mon.data.mark_kind !== want.mark_kind) begin
            report_mismatch("mark_kind", 32'(out_mon.data.mark_kind), 32'(want.mark_kind));
          end
          if (out_mon.data.mark_value !== want.mark_value) begin
            report_mismatch("mark_value", out_mon.data.mark_value, want.mark_value);
          end
        end
      end
      if (cfg_we) begin
        threshold = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        mark = next_mark(in_mon.data);
        awaited_marks.push_back(mark);
        samples_seen++;
        if (mark.mark_kind == MARK_TROUGH) troughs_seen++;
        if (mark.mark_kind == MARK_PEAK) peaks_seen++;
      end
    end
    outstanding <= awaited_marks.size();
  end

endmodule

`default_nettype wire

// File: test/zigzag_reversal_detector_core_tb.sv
// ----------------------------------------------------------------------------
// Zigzag reversal detector core testbench
// Drives price series into the core under several reversal thresholds, the
// extremes among them, with random idle bursts on both channels. A short
// directed part hits the boundary cases; the rest are random walks that
// cross the threshold, mixed with unrelated samples.
// ----------------------------------------------------------------------------
`default_nettype none

module zigzag_reversal_detector_core_tb;
  import zrd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES       = 7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [THRESH_W-1:0] cfg_wdata;
  logic                idle_on = 1'b1;
  logic [THRESH_W-1:0] cur_threshold = THRESH_RESET;
  int                  cycle_count = 0;
  int                  samples_sent = 0;
  int                  threshold_writes = 0;
  int                  mismatches;
  int                  outstanding;
  int                  samples_seen;
  int                  troughs_seen;
  int                  peaks_seen;

  zrd_in_if  in_ch ();
  zrd_out_if out_ch ();

  zigzag_reversal_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  zrd_mark_check u_mark_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .samples_seen (samples_seen),
    .troughs_seen (troughs_seen),
    .peaks_seen   (peaks_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (idle_on && $urandom_range(0, 1) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic [PORT_PRICE_W-1:0] price, input logic sos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {price, sos};
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  task automatic set_threshold(input logic [THRESH_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_threshold = value;
    threshold_writes++;
  endtask

  function automatic logic [PORT_PRICE_W-1:0] series_base();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 255);
      2:       return $urandom_range(1000, 1000000);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  // Moves the price by a percentage drawn around the current threshold, with
  // extra weight right at the threshold and one tick past it.
  function automatic logic [PORT_PRICE_W-1:0] walk_price(logic [PORT_PRICE_W-1:0] cur);
    int unsigned pct;
    logic [63:0] step;
    logic [63:0] nxt;
    case ($urandom_range(0, 5))
      0:       pct = cur_threshold;
      1:       pct = cur_threshold + 1;
      default: pct = $urandom_range(0, 2 * cur_threshold + 40);
    endcase
    step = (64'(cur) * 64'(pct)) / 64'(PCT_SCALE_SQ) + 64'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1) begin
      nxt = 64'(cur) + step;
      if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
    end else begin
      nxt = (step > 64'(cur)) ? 64'd0 : 64'(cur) - step;
    end
    return nxt[PORT_PRICE_W-1:0];
  endfunction

  task automatic run_series(input int count);
    logic [PORT_PRICE_W-1:0] price;
    price = series_base();
    send_sample(price, 1'b1);
    repeat (count - 1) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample($urandom(), 1'($urandom_range(0, 1)));
      end else begin
        price = walk_price(price);
        send_sample(price, 1'b0);
      end
    end
  endtask

  initial begin
    int target;
    int len;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Samples against the zeroed state, then boundary moves at the reset threshold.
    send_sample(32'd0, 1'b0);
    send_sample(32'd1000, 1'b0);
    send_sample(32'd10000, 1'b1);
    send_sample(32'd10500, 1'b0);
    send_sample(32'd10501, 1'b0);
    send_sample(32'd10600, 1'b0);
    send_sample(32'd10070, 1'b0);
    send_sample(32'd10069, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'd0, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b1);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'h5555_5555, 1'b1);

    set_threshold('0);
    send_sample(32'd100, 1'b1);
    send_sample(32'd100, 1'b0);
    send_sample(32'd101, 1'b0);
    send_sample(32'd100, 1'b0);

    set_threshold('1);
    send_sample(32'd1, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'd0, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_threshold(THRESH_RESET);
        1:       set_threshold('0);
        2:       set_threshold('1);
        3:       set_threshold(16'($urandom_range(1, 200)));
        4:       set_threshold(16'($urandom_range(200, 2000)));
        5:       set_threshold(16'($urandom()));
        default: set_threshold(16'($urandom_range(1, 1000)));
      endcase
      if (phase == PHASES - 1) idle_on = 1'b0;
      target = samples_sent + RANDOM_ITEMS / PHASES;
      while (samples_sent < target) begin
        len = $urandom_range(3, 40);
        if (len > target - samples_sent) len = target - samples_sent;
        run_series(len);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d samples over %0d threshold settings, including 0 and 65535.",
             samples_seen, threshold_writes);
    $display("Marks predicted: %0d troughs, %0d peaks; mismatches: %0d.",
             troughs_seen, peaks_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/zrd_pkg.sv
sv/zrd_if.sv
sv/zigzag_reversal_detector_core.sv
test/zrd_mark_check.sv
test/zigzag_reversal_detector_core_tb.sv
